// ===== rtl/tsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbc_pkg
// Shared types, constants and helper functions for the subtract-with-carry
// register execute block.
// ----------------------------------------------------------------------------
package tsbc_pkg;

	localparam int NUM_REGS_DEF = 16;
	localparam int REG_IDX_W    = 4;

	localparam logic [REG_IDX_W-1:0] PC_IDX = 4'd15;

	localparam logic [31:0] STEP_NARROW = 32'd2;
	localparam logic [31:0] STEP_WIDE   = 32'd4;

	// Shift types of the wide encoding
	localparam logic [1:0] SHT_LSL = 2'd0;
	localparam logic [1:0] SHT_LSR = 2'd1;
	localparam logic [1:0] SHT_ASR = 2'd2;
	localparam logic [1:0] SHT_ROR = 2'd3;

	// Condition groups, cond[3:1]; cond[0] inverts
	localparam logic [2:0] CG_EQ = 3'd0;
	localparam logic [2:0] CG_CS = 3'd1;
	localparam logic [2:0] CG_MI = 3'd2;
	localparam logic [2:0] CG_VS = 3'd3;
	localparam logic [2:0] CG_HI = 3'd4;
	localparam logic [2:0] CG_GE = 3'd5;
	localparam logic [2:0] CG_GT = 3'd6;

	// Flag bit positions in NZCV
	localparam int FL_N = 3;
	localparam int FL_Z = 2;
	localparam int FL_C = 1;
	localparam int FL_V = 0;

	typedef struct packed {
		logic [31:0] instruction;
		logic        is_wide;
		logic        in_it_block;
		logic [3:0]  it_condition;
	} in_word_t;

	typedef struct packed {
		logic        executed;
		logic [3:0]  dest_index;
		logic [31:0] result_value;
		logic [3:0]  flags_nzcv;
		logic [31:0] next_pc;
	} out_word_t;

	// Decoded instruction, held while the operands are read
	typedef struct packed {
		logic [REG_IDX_W-1:0] rn;
		logic [REG_IDX_W-1:0] rm;
		logic [REG_IDX_W-1:0] rd;
		logic                 setf;
		logic [1:0]           shtype;
		logic [4:0]           imm;
		logic                 wide;
		logic                 in_it;
		logic [3:0]           cond;
	} dec_t;

	// ALU control and result
	typedef struct packed {
		logic [1:0] shtype;
		logic [4:0] imm;
		logic       cin;
	} alu_ctl_t;

	typedef struct packed {
		logic [31:0] result;
		logic [3:0]  nzcv;
	} alu_res_t;

	// Field decode of both encodings
	function automatic dec_t decode(input in_word_t w);
		dec_t d;
		d.wide  = w.is_wide;
		d.in_it = w.in_it_block;
		d.cond  = w.it_condition;
		if (w.is_wide) begin
			d.rm     = w.instruction[3:0];
			d.rd     = w.instruction[11:8];
			d.rn     = w.instruction[19:16];
			d.setf   = w.instruction[20];
			d.shtype = w.instruction[5:4];
			d.imm    = {w.instruction[14:12], w.instruction[7:6]};
		end else begin
			d.rm     = {1'b0, w.instruction[21:19]};
			d.rd     = {1'b0, w.instruction[18:16]};
			d.rn     = {1'b0, w.instruction[18:16]};
			d.setf   = ~w.in_it_block;
			d.shtype = SHT_LSL;
			d.imm    = 5'd0;
		end
		return d;
	endfunction

	// Condition check against NZCV; codes 14 and 15 always pass
	function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
		logic r;
		logic always_pass;
		always_pass = 1'b0;
		case (cond[3:1])
			CG_EQ:   r = f[FL_Z];
			CG_CS:   r = f[FL_C];
			CG_MI:   r = f[FL_N];
			CG_VS:   r = f[FL_V];
			CG_HI:   r = f[FL_C] & ~f[FL_Z];
			CG_GE:   r = (f[FL_N] == f[FL_V]);
			CG_GT:   r = ~f[FL_Z] & (f[FL_N] == f[FL_V]);
			default: begin
				r           = 1'b1;
				always_pass = 1'b1;
			end
		endcase
		return always_pass ? 1'b1 : (cond[0] ? ~r : r);
	endfunction

endpackage

// ===== rtl/tsbc_ram.sv =====
// ----------------------------------------------------------------------------
// tsbc_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module tsbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/tsbc_alu.sv =====
// ----------------------------------------------------------------------------
// tsbc_alu
// Immediate shifter and subtract-with-carry adder with NZCV generation.
// ----------------------------------------------------------------------------
module tsbc_alu
	import tsbc_pkg::*;
(
	input  logic [31:0] op_a,
	input  logic [31:0] op_m,
	input  alu_ctl_t    ctl,
	output alu_res_t    res
);

	logic [31:0] shifted;
	logic [63:0] rot_dbl;
	logic [31:0] op_b;
	logic [32:0] sum;

	// Shift of Rm; an amount of zero encodes the special forms
	always_comb begin
		rot_dbl = {op_m, op_m} >> ctl.imm;
		case (ctl.shtype)
			SHT_LSL: shifted = op_m << ctl.imm;
			SHT_LSR: shifted = (ctl.imm == 5'd0) ? 32'd0 : (op_m >> ctl.imm);
			SHT_ASR: shifted = (ctl.imm == 5'd0) ? {32{op_m[31]}}
			                                     : 32'($signed(op_m) >>> ctl.imm);
			SHT_ROR: shifted = (ctl.imm == 5'd0) ? {ctl.cin, op_m[31:1]}
			                                     : rot_dbl[31:0];
			default: shifted = op_m;
		endcase
	end

	// Rn + NOT(op2) + C
	assign op_b = ~shifted;
	assign sum  = {1'b0, op_a} + {1'b0, op_b} + {32'd0, ctl.cin};

	always_comb begin
		res.result       = sum[31:0];
		res.nzcv[FL_N]   = sum[31];
		res.nzcv[FL_Z]   = (sum[31:0] == 32'd0);
		res.nzcv[FL_C]   = sum[32];
		res.nzcv[FL_V]   = (op_a[31] ^ sum[31]) & (op_b[31] ^ sum[31]);
	end

endmodule

// ===== rtl/thumb_sbc_register_execute.sv =====
// ----------------------------------------------------------------------------
// thumb_sbc_register_execute
// Subtract-with-carry register execute unit: register file in RAM, PC and
// NZCV in flops, one instruction word in and one result word out.
// ----------------------------------------------------------------------------
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+-------------------------------
//  in       | in_valid / in_ready / in_word   | in_word_t  (instruction word)
//  out      | out_valid / out_ready / out_word| out_word_t (result word)
//
// One word per cycle sustained. A word is decoded on acceptance while Rn and
// Rm are read from the register RAM; the execute stage then computes and
// commits to the RAM, PC and flags as the result enters the output
// register. A result written in one cycle is forwarded to the word accepted
// on the same edge. Reset clears PC, flags and the per-register valid bits
// (unwritten registers read as zero); no clearing pass is needed. A stalled
// output holds the word in the execute stage and drops in_ready.
// ----------------------------------------------------------------------------
module thumb_sbc_register_execute
	import tsbc_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int IDX_W = $clog2(NUM_REGS);

	// Execute stage
	logic                 s1_valid_q;
	dec_t                 dec_s1;
	logic                 fwd_rn_s1;
	logic                 fwd_rm_s1;
	logic                 vld_rn_s1;
	logic                 vld_rm_s1;
	logic [31:0]          fwd_val_s1;

	// Architectural state outside the RAM
	logic [3:0]           flags_q;
	logic [31:0]          pc_q;
	logic [NUM_REGS-1:0]  reg_vld_q;

	// Output register
	logic                 out_valid_q;
	out_word_t            out_word_q;

	logic                 accept;
	logic                 advance;
	dec_t                 dec_in;
	logic [31:0]          ram_rd_a;
	logic [31:0]          ram_rd_b;
	logic [31:0]          rn_val;
	logic [31:0]          rm_val;
	logic                 exec;
	logic                 ram_we;
	logic                 pc_dest;
	logic [31:0]          pc_base;
	logic [31:0]          pc_next;
	logic [3:0]           flags_next;
	alu_ctl_t             alu_ctl;
	alu_res_t             alu_res;

	// Handshake
	assign advance  = s1_valid_q & (out_ready | ~out_valid_q);
	assign in_ready = ~s1_valid_q | advance;
	assign accept   = in_valid & in_ready;
	assign dec_in   = decode(in_word);

	// Register file
	tsbc_ram #(
		.WIDTH (32),
		.DEPTH (NUM_REGS)
	) u_regs (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (IDX_W'(dec_s1.rd)),
		.wdata   (alu_res.result),
		.re      (accept),
		.raddr_a (IDX_W'(dec_in.rn)),
		.raddr_b (IDX_W'(dec_in.rm)),
		.rdata_a (ram_rd_a),
		.rdata_b (ram_rd_b)
	);

	// Operand select: PC, forwarded write, RAM, or zero if never written
	always_comb begin
		if (dec_s1.rn == PC_IDX) begin
			rn_val = pc_q;
		end else if (fwd_rn_s1) begin
			rn_val = fwd_val_s1;
		end else begin
			rn_val = vld_rn_s1 ? ram_rd_a : 32'd0;
		end
		if (dec_s1.rm == PC_IDX) begin
			rm_val = pc_q;
		end else if (fwd_rm_s1) begin
			rm_val = fwd_val_s1;
		end else begin
			rm_val = vld_rm_s1 ? ram_rd_b : 32'd0;
		end
	end

	assign alu_ctl.shtype = dec_s1.shtype;
	assign alu_ctl.imm    = dec_s1.imm;
	assign alu_ctl.cin    = flags_q[FL_C];

	tsbc_alu u_alu (
		.op_a (rn_val),
		.op_m (rm_val),
		.ctl  (alu_ctl),
		.res  (alu_res)
	);

	// Commit logic
	assign exec       = dec_s1.in_it ? cond_pass(dec_s1.cond, flags_q) : 1'b1;
	assign pc_dest    = exec & (dec_s1.rd == PC_IDX);
	assign ram_we     = advance & exec & ~pc_dest;
	assign pc_base    = pc_dest ? alu_res.result : pc_q;
	assign pc_next    = pc_base + (dec_s1.wide ? STEP_WIDE : STEP_NARROW);
	assign flags_next = (exec & dec_s1.setf) ? alu_res.nzcv : flags_q;

	// Execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Execute stage payload, valid bits sampled with the RAM read
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1     <= dec_in;
			vld_rn_s1  <= reg_vld_q[IDX_W'(dec_in.rn)];
			vld_rm_s1  <= reg_vld_q[IDX_W'(dec_in.rm)];
			fwd_rn_s1  <= ram_we & (dec_s1.rd == dec_in.rn);
			fwd_rm_s1  <= ram_we & (dec_s1.rd == dec_in.rm);
			fwd_val_s1 <= alu_res.result;
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= 4'd0;
			pc_q      <= 32'd0;
			reg_vld_q <= '0;
		end else if (advance) begin
			flags_q <= flags_next;
			pc_q    <= pc_next;
			if (ram_we) begin
				reg_vld_q[IDX_W'(dec_s1.rd)] <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.executed     <= exec;
			out_word_q.dest_index   <= dec_s1.rd;
			out_word_q.result_value <= exec ? alu_res.result : 32'd0;
			out_word_q.flags_nzcv   <= flags_next;
			out_word_q.next_pc      <= pc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Checks
	a_no_pc_in_ram: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (dec_s1.rd != PC_IDX))
		else $error("register RAM written at the PC index");

	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("committed word missing from output register");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> in_ready)
		else $error("empty execute stage refuses input");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_word_q.executed || (out_word_q.result_value == 32'd0)))
		else $error("skipped instruction carries a non-zero result");

endmodule
